// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module of the project.
// Each macro needs clk in scope; all but AST_NXT_RST also need rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define AST_NXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

// ----- design/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// acm_pkg
// Shared widths and codes of the multi-pattern matcher: operation codes of an
// input transfer and status codes of a result transfer.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 5;
  localparam int STAT_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOBLD = 2'd2;

endpackage

// ----- design/aho_corasick_matcher.sv -----
// ----------------------------------------------------------------------------
// aho_corasick_matcher
// Multi-pattern matcher: trie insert, breadth-first failure link build and
// automaton walk, all kept in single-port-read synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   An input transfer happens at a clock edge with start high and busy low.
//   Every input transfer gives exactly one result transfer: out_strobe is high
//   for one cycle with out_status, out_found and out_query_done valid.
//   The receiver cannot stall.
// Steps from an input transfer to its result transfer:
//   clear, a dropped pattern letter and a rejected or already-found query
//   answer from the idle state. A pattern letter reads the child, then
//   writes the child and mark. A query letter reads the child memory; on a
//   hit it reads the match mark, on a miss at the root it answers, else it
//   reads the failure link memory and reads the child again. The build pops
//   each queued node and reads the child of every letter slot; for each
//   child found it follows failure links, then stores the link and mark.
// Reset and the clear operation both start a sweep that zeroes the child
//   memory and the match marks, one entry per cycle, across the
//   MAX_NODES*ALPHABET_SIZE entries; busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
module aho_corasick_matcher #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [acm_pkg::OP_W-1:0]   in_operation,
  input  logic [acm_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_first_of_word,
  input  logic                       in_last_of_word,
  output logic                       out_strobe,
  output logic [acm_pkg::STAT_W-1:0] out_status,
  output logic                       out_found,
  output logic                       out_query_done
);

  import acm_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = NW + 1;
  localparam int SW    = $clog2(ALPHABET_SIZE);
  localparam int LW    = ((SW > SYM_W) ? SW : SYM_W) + 1;
  localparam int DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int CAW   = $clog2(DEPTH);

  localparam logic [CAW-1:0] ALPHA_A    = CAW'(ALPHABET_SIZE);
  localparam logic [CAW-1:0] SWEEP_LAST = CAW'(DEPTH - 1);
  localparam logic [CAW-1:0] MARK_SPAN  = CAW'(MAX_NODES);
  localparam logic [SW-1:0]  SYM_LAST   = SW'(ALPHABET_SIZE - 1);
  localparam logic [LW-1:0]  SYM_LIMIT  = LW'(ALPHABET_SIZE);
  localparam logic [CW-1:0]  NODE_LIMIT = CW'(MAX_NODES);

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_INS    = 13'b0000000000100,
    ST_QCHILD = 13'b0000000001000,
    ST_QFAIL  = 13'b0000000010000,
    ST_QMARK  = 13'b0000000100000,
    ST_BPOP   = 13'b0000001000000,
    ST_BCUR   = 13'b0000010000000,
    ST_BCHILD = 13'b0000100000000,
    ST_BFAIL  = 13'b0001000000000,
    ST_BDEST  = 13'b0010000000000,
    ST_BSET   = 13'b0100000000000,
    ST_BMARK  = 13'b1000000000000
  } state_t;

  // Memories.
  logic [NW-1:0] child_mem [DEPTH];
  logic [NW-1:0] fail_mem  [MAX_NODES];
  logic          mark_mem  [MAX_NODES];
  logic [NW-1:0] queue_mem [MAX_NODES];

  // Control registers.
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [NW-1:0] ins_r, ins_nxt;
  logic [NW-1:0] scan_r, scan_nxt;
  logic          found_r, found_nxt;
  logic          built_r, built_nxt;
  logic          drop_r, drop_nxt;
  logic [CAW-1:0] clr_r, clr_nxt;
  logic          strobe_r, strobe_nxt;

  // Working registers.
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [NW-1:0] kid_r, kid_nxt;
  logic [NW-1:0] dest_r, dest_nxt;
  logic          last_r, last_nxt;
  logic          symok_r, symok_nxt;
  logic [LW-1:0] sym_r, sym_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic          ofound_r, ofound_nxt;
  logic          done_r, done_nxt;
  logic [CAW-1:0] caddr_r;

  // Memory ports.
  logic [NW-1:0]  c_node;
  logic [LW-1:0]  c_let;
  logic [CAW-1:0] caddr;
  logic [NW-1:0]  cdata_r;
  logic           c_we;
  logic [CAW-1:0] c_wa;
  logic [NW-1:0]  c_wd;
  logic [NW-1:0]  f_ra, f_wa, f_wd, fdata_r;
  logic           f_we;
  logic [NW-1:0]  m_ra, m_wa;
  logic           m_we, m_wd, mdata_r;
  logic [NW-1:0]  q_ra, q_wa, q_wd, qdata_r;
  logic           q_we;

  // Decode helpers.
  logic           accept;
  logic [LW-1:0]  sym_in;
  logic           sym_bad;
  logic [NW-1:0]  ins_eff, scan_eff;
  logic           drop_eff, found_eff;
  logic [NW-1:0]  qkid;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign sym_in  = LW'(in_symbol);
  assign sym_bad = (sym_in >= SYM_LIMIT);
  assign ins_eff   = in_first_of_word ? '0 : ins_r;
  assign drop_eff  = in_first_of_word ? 1'b0 : drop_r;
  assign scan_eff  = in_first_of_word ? '0 : scan_r;
  assign found_eff = in_first_of_word ? 1'b0 : found_r;
  // A query letter out of the alphabet has no child anywhere.
  assign qkid = symok_r ? cdata_r : '0;

  // Flat child address: node times alphabet size plus letter.
  assign caddr = CAW'(c_node) * ALPHA_A + CAW'(c_let);

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ins_nxt    = ins_r;
    scan_nxt   = scan_r;
    found_nxt  = found_r;
    built_nxt  = built_r;
    drop_nxt   = drop_r;
    clr_nxt    = clr_r;
    strobe_nxt = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    s_nxt      = s_r;
    kid_nxt    = kid_r;
    dest_nxt   = dest_r;
    last_nxt   = last_r;
    symok_nxt  = symok_r;
    sym_nxt    = sym_r;
    status_nxt = status_r;
    ofound_nxt = ofound_r;
    done_nxt   = done_r;
    c_node = cur_r;
    c_let  = '0;
    c_we = 1'b0;  c_wa = caddr_r;  c_wd = '0;
    f_ra = cur_r;
    f_we = 1'b0;  f_wa = kid_r;    f_wd = dest_r;
    m_ra = dest_r;
    m_we = 1'b0;  m_wa = kid_r;    m_wd = 1'b1;
    q_ra = head_r[NW-1:0];
    q_we = 1'b0;  q_wa = tail_r[NW-1:0];  q_wd = kid_r;

    unique case (state_r)
      ST_CLEAR: begin
        // Zero one child entry and, in the low range, one match mark.
        c_we = 1'b1;
        c_wa = clr_r;
        c_wd = '0;
        if (clr_r < MARK_SPAN) begin
          m_we = 1'b1;
          m_wa = clr_r[NW-1:0];
          m_wd = 1'b0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SWEEP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          last_nxt   = in_last_of_word;
          sym_nxt    = sym_in;
          symok_nxt  = !sym_bad;
          status_nxt = STATUS_OK;
          ofound_nxt = 1'b0;
          done_nxt   = 1'b0;
          unique case (in_operation)
            OP_PATTERN: begin
              built_nxt = 1'b0;
              ins_nxt   = ins_eff;
              drop_nxt  = drop_eff;
              if (drop_eff) begin
                status_nxt = STATUS_FULL;
                strobe_nxt = 1'b1;
              end else if (sym_bad) begin
                drop_nxt   = 1'b1;
                strobe_nxt = 1'b1;
              end else begin
                c_node    = ins_eff;
                c_let     = sym_in;
                state_nxt = ST_INS;
              end
            end
            OP_BUILD: begin
              f_we = 1'b1;  f_wa = '0;  f_wd = '0;
              q_we = 1'b1;  q_wa = '0;  q_wd = '0;
              head_nxt  = '0;
              tail_nxt  = CW'(1);
              state_nxt = ST_BPOP;
            end
            OP_QUERY: begin
              done_nxt = in_last_of_word;
              if (!built_r) begin
                status_nxt = STATUS_NOBLD;
                strobe_nxt = 1'b1;
              end else begin
                scan_nxt  = scan_eff;
                found_nxt = found_eff;
                if (found_eff) begin
                  ofound_nxt = 1'b1;
                  strobe_nxt = 1'b1;
                end else begin
                  c_node    = scan_eff;
                  c_let     = sym_in;
                  state_nxt = ST_QCHILD;
                end
              end
            end
            OP_CLEAR: begin
              count_nxt  = CW'(1);
              ins_nxt    = '0;
              scan_nxt   = '0;
              found_nxt  = 1'b0;
              built_nxt  = 1'b0;
              drop_nxt   = 1'b0;
              clr_nxt    = '0;
              strobe_nxt = 1'b1;
              state_nxt  = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_INS: begin
        // Follow an existing edge, allocate the next free node or report a full table.
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if (cdata_r != '0) begin
          ins_nxt = cdata_r;
          m_we    = last_r;
          m_wa    = cdata_r;
        end else if (count_r < NODE_LIMIT) begin
          c_we      = 1'b1;
          c_wa      = caddr_r;
          c_wd      = count_r[NW-1:0];
          ins_nxt   = count_r[NW-1:0];
          count_nxt = count_r + 1'b1;
          m_we      = last_r;
          m_wa      = count_r[NW-1:0];
        end else begin
          drop_nxt   = 1'b1;
          status_nxt = STATUS_FULL;
        end
      end

      ST_QCHILD: begin
        if (qkid != '0) begin
          scan_nxt  = qkid;
          m_ra      = qkid;
          state_nxt = ST_QMARK;
        end else if (scan_r == '0) begin
          // Miss at the root: the root never carries a match mark.
          ofound_nxt = 1'b0;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          f_ra      = scan_r;
          state_nxt = ST_QFAIL;
        end
      end

      ST_QFAIL: begin
        scan_nxt  = fdata_r;
        c_node    = fdata_r;
        c_let     = sym_r;
        state_nxt = ST_QCHILD;
      end

      ST_QMARK: begin
        found_nxt  = mdata_r;
        ofound_nxt = mdata_r;
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end

      ST_BPOP: begin
        if (head_r == tail_r) begin
          built_nxt  = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          q_ra      = head_r[NW-1:0];
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_BCUR;
        end
      end

      ST_BCUR: begin
        cur_nxt   = qdata_r;
        s_nxt     = '0;
        c_node    = qdata_r;
        c_let     = '0;
        state_nxt = ST_BCHILD;
      end

      ST_BCHILD: begin
        kid_nxt = cdata_r;
        if (cdata_r == '0) begin
          if (s_r == SYM_LAST) begin
            state_nxt = ST_BPOP;
          end else begin
            s_nxt  = s_r + 1'b1;
            c_node = cur_r;
            c_let  = LW'(s_r) + 1'b1;
          end
        end else if (cur_r == '0) begin
          dest_nxt  = '0;
          state_nxt = ST_BSET;
        end else begin
          f_ra      = cur_r;
          state_nxt = ST_BFAIL;
        end
      end

      ST_BFAIL: begin
        dest_nxt  = fdata_r;
        c_node    = fdata_r;
        c_let     = LW'(s_r);
        state_nxt = ST_BDEST;
      end

      ST_BDEST: begin
        if (cdata_r != '0) begin
          dest_nxt  = cdata_r;
          state_nxt = ST_BSET;
        end else if (dest_r == '0) begin
          state_nxt = ST_BSET;
        end else begin
          f_ra      = dest_r;
          state_nxt = ST_BFAIL;
        end
      end

      ST_BSET: begin
        // Store the link, fetch the target's mark, enqueue the child.
        f_we = 1'b1;
        f_wa = kid_r;
        f_wd = dest_r;
        m_ra = dest_r;
        if (tail_r < NODE_LIMIT) begin
          q_we     = 1'b1;
          q_wa     = tail_r[NW-1:0];
          q_wd     = kid_r;
          tail_nxt = tail_r + 1'b1;
        end
        state_nxt = ST_BMARK;
      end

      ST_BMARK: begin
        m_we = mdata_r;
        m_wa = kid_r;
        m_wd = 1'b1;
        if (s_r == SYM_LAST) begin
          state_nxt = ST_BPOP;
        end else begin
          s_nxt     = s_r + 1'b1;
          c_node    = cur_r;
          c_let     = LW'(s_r) + 1'b1;
          state_nxt = ST_BCHILD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      count_r  <= CW'(1);
      ins_r    <= '0;
      scan_r   <= '0;
      found_r  <= 1'b0;
      built_r  <= 1'b0;
      drop_r   <= 1'b0;
      clr_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ins_r    <= ins_nxt;
      scan_r   <= scan_nxt;
      found_r  <= found_nxt;
      built_r  <= built_nxt;
      drop_r   <= drop_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    cur_r    <= cur_nxt;
    s_r      <= s_nxt;
    kid_r    <= kid_nxt;
    dest_r   <= dest_nxt;
    last_r   <= last_nxt;
    symok_r  <= symok_nxt;
    sym_r    <= sym_nxt;
    status_r <= status_nxt;
    ofound_r <= ofound_nxt;
    done_r   <= done_nxt;
    caddr_r  <= caddr;
  end

  // Child memory: the insert writes back at the address it read last cycle.
  always_ff @(posedge clk) begin
    if (c_we) begin
      child_mem[c_wa] <= c_wd;
    end
    cdata_r <= child_mem[caddr];
  end

  // Failure link memory.
  always_ff @(posedge clk) begin
    if (f_we) begin
      fail_mem[f_wa] <= f_wd;
    end
    fdata_r <= fail_mem[f_ra];
  end

  // Match mark memory.
  always_ff @(posedge clk) begin
    if (m_we) begin
      mark_mem[m_wa] <= m_wd;
    end
    mdata_r <= mark_mem[m_ra];
  end

  // Breadth-first queue memory.
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    qdata_r <= queue_mem[q_ra];
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_found      = ofound_r;
  assign out_query_done = done_r;

endmodule

// ----- design/acm_checker.sv -----
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks of the matcher: result encoding and transfer progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic [acm_pkg::STAT_W-1:0] out_status,
  input logic                       out_found,
  input logic                       out_query_done
);

  import acm_pkg::*;

  // Reset always starts the memory sweep.
  `AST_NXT_RST(a_reset_sweep, !rst_n, busy)

  // An input transfer is either answered or still being worked on.
  `AST_NXT(a_progress, start && !busy, out_strobe || busy)

  // A reported match only comes with an ok status.
  `AST_IMP(a_found_ok, out_strobe && out_found, out_status == STATUS_OK)

  // A full table answer belongs to a pattern letter, never to a query.
  `AST_IMP(a_full_enc, out_strobe && out_status == STATUS_FULL, !out_found && !out_query_done)

  // A rejected query never reports a match.
  `AST_IMP(a_nobld_enc, out_strobe && out_status == STATUS_NOBLD, !out_found)

endmodule

bind aho_corasick_matcher acm_checker u_acm_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Multi-pattern matcher testbench
// Drives pattern, build, query and clear transfers into the matcher and
// checks every result transfer against a predictor kept inside the bench or,
// for some directed rows, a typed result. A short directed table comes first.
// Random rounds follow: they insert patterns, build the links, run queries
// and clear, with one round that fills the node table.
// ----------------------------------------------------------------------------
module tb;
  import acm_pkg::*;

  localparam int MAXN     = 1024;
  localparam int ALPH     = 26;
  localparam int N_RANDOM = 1250;
  localparam int WD_LIMIT = 500000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic              done;
  } match_res_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic              first;
    logic              last;
    logic              typed;
    logic [STAT_W-1:0] status;
    logic              found;
    logic              done;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = OP_CLEAR;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              in_first_of_word = 1'b0;
  logic              in_last_of_word = 1'b0;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic              out_found;
  logic              out_query_done;

  // Matcher state as the predictor sees it.
  int unsigned trie_child [MAXN*ALPH];
  int unsigned fail_link [MAXN];
  bit          is_match [MAXN];
  int unsigned node_total;
  int unsigned ins_node;
  int unsigned walk_node;
  bit          hit_flag;
  bit          links_ready;
  bit          ins_dropped;

  match_res_t  pending_results [$];
  int          fail_count = 0;
  int          item_count = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  aho_corasick_matcher DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_symbol        (in_symbol),
    .in_first_of_word (in_first_of_word),
    .in_last_of_word  (in_last_of_word),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_query_done   (out_query_done)
  );

  function automatic int unsigned child_at(int unsigned node, int unsigned sym);
    if (sym >= ALPH || node >= MAXN) return 0;
    return trie_child[node*ALPH + sym];
  endfunction

  function automatic void clear_trie();
    foreach (trie_child[i]) trie_child[i] = 0;
    foreach (fail_link[i]) fail_link[i] = 0;
    foreach (is_match[i]) is_match[i] = 1'b0;
    node_total  = 1;
    ins_node    = 0;
    walk_node   = 0;
    hit_flag    = 1'b0;
    links_ready = 1'b0;
    ins_dropped = 1'b0;
  endfunction

  // Breadth-first walk that sets failure links and inherits match marks.
  function automatic void build_fail_links();
    int unsigned order [$];
    int unsigned cur;
    int unsigned nxt;
    int unsigned dest;
    int unsigned guard;
    fail_link[0] = 0;
    order = {order, 0};
    while (order.size() > 0) begin
      cur = order.pop_front();
      for (int s = 0; s < ALPH; s++) begin
        nxt = child_at(cur, s);
        if (nxt == 0) continue;
        if (cur == 0) begin
          dest = 0;
        end else begin
          dest = fail_link[cur];
          guard = 0;
          while (dest != 0 && child_at(dest, s) == 0 && guard < MAXN) begin
            dest = fail_link[dest];
            guard++;
          end
          if (child_at(dest, s) != 0) dest = child_at(dest, s);
        end
        fail_link[nxt] = dest;
        if (is_match[dest]) is_match[nxt] = 1'b1;
        order = {order, nxt};
      end
    end
    links_ready = 1'b1;
  endfunction

  // Next state and result of one accepted input transfer.
  function automatic match_res_t predict_match(logic [OP_W-1:0] op, int unsigned sym,
                                               bit first, bit last);
    match_res_t r;
    int unsigned nxt;
    int unsigned guard;
    r = '0;
    case (op)
      OP_PATTERN: begin
        links_ready = 1'b0;
        if (first) begin
          ins_node = 0;
          ins_dropped = 1'b0;
        end
        if (ins_dropped) begin
          r.status = STATUS_FULL;
        end else if (sym >= ALPH) begin
          ins_dropped = 1'b1;
        end else begin
          nxt = child_at(ins_node, sym);
          if (nxt == 0) begin
            if (node_total < MAXN) begin
              nxt = node_total++;
              trie_child[ins_node*ALPH + sym] = nxt;
            end else begin
              ins_dropped = 1'b1;
              r.status = STATUS_FULL;
            end
          end
          if (!ins_dropped) begin
            ins_node = nxt;
            if (last) is_match[ins_node] = 1'b1;
          end
        end
      end
      OP_BUILD: build_fail_links();
      OP_QUERY: begin
        r.done = last;
        if (!links_ready) begin
          r.status = STATUS_NOBLD;
        end else begin
          if (first) begin
            walk_node = 0;
            hit_flag = 1'b0;
          end
          if (!hit_flag) begin
            guard = 0;
            while (walk_node != 0 && child_at(walk_node, sym) == 0 && guard < MAXN) begin
              walk_node = fail_link[walk_node];
              guard++;
            end
            if (child_at(walk_node, sym) != 0) walk_node = child_at(walk_node, sym);
            if (is_match[walk_node]) hit_flag = 1'b1;
          end
          r.found = hit_flag;
        end
      end
      default: clear_trie();
    endcase
    return r;
  endfunction

  // One input transfer; the result is predicted at the accepting edge.
  task automatic send_item(logic [OP_W-1:0] op, int unsigned sym, bit first, bit last,
                           bit typed = 1'b0, match_res_t typed_res = '0);
    match_res_t r;
    start            <= 1'b1;
    in_operation     <= op;
    in_symbol        <= sym[SYM_W-1:0];
    in_first_of_word <= first;
    in_last_of_word  <= last;
    do @(posedge clk); while (busy);
    r = predict_match(op, sym, first, last);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
    item_count++;
    // Sender gaps.
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_symbol(int unsigned hi);
    if ($urandom_range(99) < 95) return $urandom_range(hi);
    return $urandom_range(31);
  endfunction

  // Inserts patterns, may send a stray query, builds, then runs queries over the same letters.
  task automatic run_round(int unsigned hi, int n_pat, int max_len, int n_query);
    int len;
    for (int p = 0; p < n_pat; p++) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++)
        send_item(OP_PATTERN, pick_symbol(hi), (i == 0) && ($urandom_range(9) != 0),
                  i == len - 1);
    end
    // A stray query before the build is rejected.
    if ($urandom_range(3) == 0)
      send_item(OP_QUERY, pick_symbol(hi), 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_item(OP_BUILD, $urandom_range(31), 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int q = 0; q < n_query; q++) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        send_item(OP_QUERY, pick_symbol(hi), (i == 0) && ($urandom_range(9) != 0),
                  i == len - 1);
    end
  endtask

  // Fills the node table, then keeps inserting to hit the full case, builds and runs queries.
  task automatic fill_table();
    while (node_total < MAXN)
      for (int i = 0; i < 12; i++)
        send_item(OP_PATTERN, $urandom_range(ALPH - 1), i == 0, i == 11);
    for (int p = 0; p < 3; p++)
      for (int i = 0; i < 5; i++)
        send_item(OP_PATTERN, $urandom_range(ALPH - 1), i == 0, i == 4);
    send_item(OP_BUILD, 0, 1'b0, 1'b0);
    for (int i = 0; i < 60; i++)
      send_item(OP_QUERY, $urandom_range(ALPH - 1), i % 6 == 0, i % 6 == 5);
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    match_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          fail_count++;
        end
        if (out_query_done !== want.done) begin
          $error("query_done: expected %0d, got %0d", want.done, out_query_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Directed rows: typed results where they are obvious, else predicted.
  localparam stim_row_t DIRECTED [20] = '{
    '{OP_QUERY,   5'd0,  1'b1, 1'b1, 1'b1, STATUS_NOBLD, 1'b0, 1'b1},
    '{OP_PATTERN, 5'd7,  1'b1, 1'b0, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd4,  1'b0, 1'b1, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd18, 1'b1, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd7,  1'b0, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd4,  1'b0, 1'b1, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd31, 1'b1, 1'b0, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd1,  1'b0, 1'b1, 1'b1, STATUS_FULL,  1'b0, 1'b0},
    '{OP_PATTERN, 5'd25, 1'b1, 1'b1, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_BUILD,   5'd0,  1'b0, 1'b0, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd18, 1'b1, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd7,  1'b0, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd4,  1'b0, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd0,  1'b0, 1'b1, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd31, 1'b1, 1'b1, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd25, 1'b1, 1'b0, 1'b0, STATUS_OK,    1'b0, 1'b0},
    '{OP_PATTERN, 5'd0,  1'b1, 1'b1, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd0,  1'b1, 1'b0, 1'b1, STATUS_NOBLD, 1'b0, 1'b0},
    '{OP_CLEAR,   5'd0,  1'b0, 1'b0, 1'b1, STATUS_OK,    1'b0, 1'b0},
    '{OP_QUERY,   5'd3,  1'b1, 1'b1, 1'b1, STATUS_NOBLD, 1'b0, 1'b1}
  };

  initial begin
    int round;
    clear_trie();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].first, DIRECTED[i].last,
                DIRECTED[i].typed,
                '{DIRECTED[i].status, DIRECTED[i].found, DIRECTED[i].done});

    // Random rounds; the gap rate changes between rounds.
    round = 0;
    item_count = 0;
    while (item_count < N_RANDOM) begin
      case (round % 4)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 9;
        default: idle_pct = 57;
      endcase
      if (round == 5) begin
        fill_table();
        send_item(OP_CLEAR, 0, 1'b0, 1'b0);
      end else begin
        run_round((round % 2) ? 3 : 7, $urandom_range(2, 6), 5, $urandom_range(4, 10));
      end
      if (round % 6 == 3) send_item(OP_CLEAR, $urandom_range(31), 1'b1, 1'b1);
      round++;
    end
    start <= 1'b0;

    // Drain the remaining results.
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/acm_pkg.sv
design/aho_corasick_matcher.sv
design/acm_checker.sv
tb/tb.sv
